// ===== rtl/sha256_pkg.sv =====
package sha256_pkg;

  // Input word: one message byte and its flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_t;

  // Output word: one digest word and its position
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // Sequencer to round unit
  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  // Round unit to sequencer
  typedef struct packed {
    logic busy;
    logic fin;
  } core_sts_t;

  // Sequencer to message window
  typedef struct packed {
    logic       load;
    logic [7:0] byte_val;
    logic       sched;
  } msg_ctl_t;

  localparam logic [5:0]  POS_LEN    = 6'd56;
  localparam logic [5:0]  POS_LAST   = 6'd63;
  localparam logic [5:0]  ROUND_LAST = 6'd63;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [7:0]  ZERO_BYTE  = 8'h00;
  localparam logic [63:0] BYTE_BITS  = 64'd8;
  localparam logic [2:0]  WORD_LAST  = 3'd7;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Schedule sigma functions
  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  // Round sigma functions
  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

// ===== rtl/sha256_msg.sv =====
module sha256_msg
  import sha256_pkg::*;
(
  input  logic        clk,
  input  msg_ctl_t    ctl,
  output logic [31:0] w_t
);

  // 16-word window: bytes shift in during fill, schedule words during rounds
  logic [511:0] win;
  logic [31:0]  w0, w1, w9, w14, w_new;

  assign w0  = win[511:480];
  assign w1  = win[479:448];
  assign w9  = win[223:192];
  assign w14 = win[63:32];
  assign w_t = w0;

  // Compute the next schedule word from fixed taps
  assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

  // Shift in a byte or advance the schedule
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      win <= {win[503:0], ctl.byte_val};
    end else if (ctl.sched) begin
      win <= {win[479:0], w_new};
    end
  end

endmodule

// ===== rtl/sha256_core.sv =====
module sha256_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  core_ctl_t   ctl,
  input  logic [31:0] w_t,
  output core_sts_t   sts,
  output logic [31:0] hash [8]
);

  logic [31:0] v [8];
  logic [5:0]  t;
  logic        busy;
  logic        fin;
  logic [31:0] ta, tb, mj, chs;

  assign sts.busy = busy;
  assign sts.fin  = fin;

  // One compression round on the working variables
  assign mj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign chs = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign ta  = v[7] + bsig1(v[4]) + chs + ROUND_K[t] + w_t;
  assign tb  = bsig0(v[0]) + mj;

  // Track round progress
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && t == ROUND_LAST) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  // Load and advance the working variables
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      v <= hash;
      t <= '0;
    end else if (busy) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + ta;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= ta + tb;
      t    <= t + 6'd1;
    end
  end

  // Fold the block into the hash state, or restore the initial values
  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= HASH_IV;
    end else if (ctl.init) begin
      hash <= HASH_IV;
    end else if (fin) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + v[i];
      end
    end
  end

endmodule

// ===== rtl/sha256_stream_hash_unit.sv =====
// Message bytes are taken while the sequencer is idle; the byte that fills a block starts
// a compression, and no byte is taken while the single round unit runs its 64 rounds.
// End of message: padding and length bytes are loaded, one or two compressions run,
// then 8 digest words follow at one per cycle while out_ready is high.
// Synchronous active-high rst clears the sequencer and loads the initial hash.
module sha256_stream_hash_unit
  import sha256_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  in_t  in_data,
  input  logic in_valid,
  output logic in_ready,
  output out_t out_data,
  output logic out_valid,
  input  logic out_ready
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_PAD   = 5'b00100,
    ST_LEN   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [5:0]  pos, pos_next;
  logic [63:0] bits, bits_next;
  logic        end_pend, end_pend_next;
  logic        pad_done, pad_done_next;
  logic        len_done, len_done_next;
  logic [2:0]  out_idx, out_idx_next;

  msg_ctl_t    mctl;
  core_ctl_t   cctl;
  core_sts_t   csts;
  logic [31:0] w_t;
  logic [31:0] hash [8];
  logic        accept;

  sha256_msg u_msg (
    .clk (clk),
    .ctl (mctl),
    .w_t (w_t)
  );

  sha256_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctl  (cctl),
    .w_t  (w_t),
    .sts  (csts),
    .hash (hash)
  );

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Present the digest word at the current index
  assign out_valid            = (state == ST_OUT);
  assign out_data.digest_word = hash[out_idx];
  assign out_data.word_index  = out_idx;
  assign out_data.last_word   = (out_idx == WORD_LAST);

  // Sequence fill, padding, length, compression and readout
  always_comb begin
    state_next    = state;
    pos_next      = pos;
    bits_next     = bits;
    end_pend_next = end_pend;
    pad_done_next = pad_done;
    len_done_next = len_done;
    out_idx_next  = out_idx;
    mctl.load     = 1'b0;
    mctl.byte_val = in_data.data_byte;
    mctl.sched    = csts.busy;
    cctl.start    = 1'b0;
    cctl.init     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          end_pend_next = in_data.end_of_message;
          if (in_data.byte_valid) begin
            mctl.load = 1'b1;
            pos_next  = pos + 6'd1;
            bits_next = bits + BYTE_BITS;
          end
          if (in_data.byte_valid && pos == POS_LAST) begin
            cctl.start = 1'b1;
            state_next = ST_ROUND;
          end else if (in_data.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (csts.fin) begin
          priority if (len_done) begin
            state_next = ST_OUT;
          end else if (end_pend) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        if (!pad_done || pos != POS_LEN) begin
          mctl.load     = 1'b1;
          mctl.byte_val = pad_done ? ZERO_BYTE : PAD_BYTE;
          pad_done_next = 1'b1;
          pos_next      = pos + 6'd1;
          if (pos == POS_LAST) begin
            cctl.start = 1'b1;
            state_next = ST_ROUND;
          end
        end else begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        // Shift out the bit count, most significant byte first
        mctl.load     = 1'b1;
        mctl.byte_val = bits[63:56];
        bits_next     = {bits[55:0], 8'h00};
        pos_next      = pos + 6'd1;
        if (pos == POS_LAST) begin
          len_done_next = 1'b1;
          cctl.start    = 1'b1;
          state_next    = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          out_idx_next = out_idx + 3'd1;
          if (out_idx == WORD_LAST) begin
            cctl.init     = 1'b1;
            pos_next      = '0;
            bits_next     = '0;
            end_pend_next = 1'b0;
            pad_done_next = 1'b0;
            len_done_next = 1'b0;
            state_next    = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pos      <= '0;
      bits     <= '0;
      end_pend <= 1'b0;
      pad_done <= 1'b0;
      len_done <= 1'b0;
      out_idx  <= '0;
    end else begin
      state    <= state_next;
      pos      <= pos_next;
      bits     <= bits_next;
      end_pend <= end_pend_next;
      pad_done <= pad_done_next;
      len_done <= len_done_next;
      out_idx  <= out_idx_next;
    end
  end

endmodule

// ===== rtl/sha256_checker.sv =====
module sha256_checker
  import sha256_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_ready,
  input out_t out_data,
  input logic out_valid,
  input logic out_ready
);

  // Hold a stalled digest word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("digest word changed while stalled");

  // Flag the last word exactly at index seven
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == WORD_LAST)))
    else $error("last_word does not match word_index");

  // Never take input while the digest is being read out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready during digest readout");

  // Advance the index by one after each taken word but the last
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest word index skipped");

  // Return to idle after the last word
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_word |=> !out_valid && in_ready)
    else $error("not idle after last digest word");

endmodule

bind sha256_stream_hash_unit sha256_checker u_checker (.*);
